// ===== design/sclp_pkg.sv =====
// sclp_pkg: shared types and constants for the sprite clip and uv adjust block
// used by every module of the block; no dependencies
package sclp_pkg;

    localparam int CoordW    = 16;
    localparam int EdgeW     = 18;
    localparam int DeltaW    = 19;
    localparam int SpanW     = 17;
    localparam int ProdW     = SpanW + DeltaW;
    localparam int DivW      = 35;
    localparam int StepBits  = 5;
    localparam int DivStages = DivW / StepBits;
    localparam int RemW      = 16;
    localparam int Lanes     = 4;
    localparam int BackLat   = DivStages + 3;
    localparam int QDepth    = 2;
    localparam int PtrW      = $clog2(QDepth);
    localparam int CntW      = $clog2(QDepth + 1);
    localparam int CfgIdxW   = 3;
    localparam int CfgW      = 12;

    localparam logic [CfgIdxW-1:0] CFG_ENABLE = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_LEFT   = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_TOP    = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_RIGHT  = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_BOTTOM = 3'd4;

    typedef struct packed {
        logic signed [CoordW-1:0] coord;
        logic signed [SpanW-1:0]  span;
        logic signed [DeltaW-1:0] delta;
        logic [CoordW-1:0]        size;
    } lane_t;

    typedef struct packed {
        logic [CoordW-1:0] pos_x;
        logic [CoordW-1:0] pos_y;
        logic [CoordW-1:0] width;
        logic [CoordW-1:0] height;
        logic [CoordW-1:0] texture_id;
        logic [31:0]       colour_rgba;
    } pass_t;

    typedef struct packed {
        pass_t             pass;
        lane_t [Lanes-1:0] lane;
    } job_t;

endpackage

// ===== design/sprite_clip_uv_adjust_core.sv =====
// sprite_clip_uv_adjust_core: top level, front classifier, queue and back pipeline
// depends on sclp_pkg, sclp_front, sclp_queue, sclp_back
// path: done pulses after the queue register, the multiply, the rounding register,
// seven radix-32 divide stages and the saturating adder in the back pipeline
// throughput: one sprite per cycle while busy is low; a culled sprite gives no transfer
// reset: asynchronous, clears the clip registers to zero and empties the pipeline
module sprite_clip_uv_adjust_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [sclp_pkg::CfgIdxW-1:0]         cfg_index,
    input  logic [sclp_pkg::CfgW-1:0]            cfg_wdata,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [sclp_pkg::CoordW-1:0]   pos_x,
    input  logic signed [sclp_pkg::CoordW-1:0]   pos_y,
    input  logic [sclp_pkg::CoordW-1:0]          width,
    input  logic [sclp_pkg::CoordW-1:0]          height,
    input  logic signed [sclp_pkg::CoordW-1:0]   tex_u1,
    input  logic signed [sclp_pkg::CoordW-1:0]   tex_v1,
    input  logic signed [sclp_pkg::CoordW-1:0]   tex_u2,
    input  logic signed [sclp_pkg::CoordW-1:0]   tex_v2,
    input  logic [sclp_pkg::CoordW-1:0]          texture_id,
    input  logic [31:0]                          colour_rgba,
    output logic                                 done,
    output logic signed [sclp_pkg::CoordW-1:0]   out_pos_x,
    output logic signed [sclp_pkg::CoordW-1:0]   out_pos_y,
    output logic [sclp_pkg::CoordW-1:0]          out_width,
    output logic [sclp_pkg::CoordW-1:0]          out_height,
    output logic signed [sclp_pkg::CoordW-1:0]   out_u1,
    output logic signed [sclp_pkg::CoordW-1:0]   out_v1,
    output logic signed [sclp_pkg::CoordW-1:0]   out_u2,
    output logic signed [sclp_pkg::CoordW-1:0]   out_v2,
    output logic [sclp_pkg::CoordW-1:0]          out_texture_id,
    output logic [31:0]                          out_colour_rgba
);

    logic           keep, full, pop, push;
    sclp_pkg::job_t job, pop_job;

    assign busy = full;
    assign push = start && !full && keep;

    sclp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .width       (width),
        .height      (height),
        .tex_u1      (tex_u1),
        .tex_v1      (tex_v1),
        .tex_u2      (tex_u2),
        .tex_v2      (tex_v2),
        .texture_id  (texture_id),
        .colour_rgba (colour_rgba),
        .keep        (keep),
        .job         (job)
    );

    sclp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (job),
        .full     (full),
        .pop      (pop),
        .pop_job  (pop_job)
    );

    sclp_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (pop),
        .in_job          (pop_job),
        .done            (done),
        .out_pos_x       (out_pos_x),
        .out_pos_y       (out_pos_y),
        .out_width       (out_width),
        .out_height      (out_height),
        .out_u1          (out_u1),
        .out_v1          (out_v1),
        .out_u2          (out_u2),
        .out_v2          (out_v2),
        .out_texture_id  (out_texture_id),
        .out_colour_rgba (out_colour_rgba)
    );

endmodule

// ===== design/sclp_front.sv =====
// sclp_front: clip registers, culling and edge clamping of one sprite
// depends on sclp_pkg
module sclp_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [sclp_pkg::CfgIdxW-1:0]         cfg_index,
    input  logic [sclp_pkg::CfgW-1:0]            cfg_wdata,
    input  logic signed [sclp_pkg::CoordW-1:0]   pos_x,
    input  logic signed [sclp_pkg::CoordW-1:0]   pos_y,
    input  logic [sclp_pkg::CoordW-1:0]          width,
    input  logic [sclp_pkg::CoordW-1:0]          height,
    input  logic signed [sclp_pkg::CoordW-1:0]   tex_u1,
    input  logic signed [sclp_pkg::CoordW-1:0]   tex_v1,
    input  logic signed [sclp_pkg::CoordW-1:0]   tex_u2,
    input  logic signed [sclp_pkg::CoordW-1:0]   tex_v2,
    input  logic [sclp_pkg::CoordW-1:0]          texture_id,
    input  logic [31:0]                          colour_rgba,
    output logic                                 keep,
    output sclp_pkg::job_t                       job
);

    logic                            en_reg;
    logic signed [sclp_pkg::CfgW-1:0] left_reg, top_reg, right_reg, bottom_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg     <= 1'b0;
            left_reg   <= '0;
            top_reg    <= '0;
            right_reg  <= '0;
            bottom_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                sclp_pkg::CFG_ENABLE: en_reg     <= cfg_wdata[0];
                sclp_pkg::CFG_LEFT:   left_reg   <= cfg_wdata;
                sclp_pkg::CFG_TOP:    top_reg    <= cfg_wdata;
                sclp_pkg::CFG_RIGHT:  right_reg  <= cfg_wdata;
                sclp_pkg::CFG_BOTTOM: bottom_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    function automatic logic signed [sclp_pkg::EdgeW-1:0] clampv(
        input logic signed [sclp_pkg::EdgeW-1:0] x,
        input logic signed [sclp_pkg::EdgeW-1:0] lo,
        input logic signed [sclp_pkg::EdgeW-1:0] hi);
        logic signed [sclp_pkg::EdgeW-1:0] r;
        begin
            r = (x < lo) ? lo : x;
            r = (r > hi) ? hi : r;
            return r;
        end
    endfunction

    logic signed [sclp_pkg::EdgeW-1:0]  el, et, er, eb, px, py, rt, bt;
    logic signed [sclp_pkg::EdgeW-1:0]  nl, nt, nr, nb;
    logic signed [sclp_pkg::SpanW-1:0]  span_u, span_v;
    logic                               cull;

    always_comb
    begin
        el = {{2{left_reg[sclp_pkg::CfgW-1]}}, left_reg, 4'b0};
        et = {{2{top_reg[sclp_pkg::CfgW-1]}}, top_reg, 4'b0};
        er = {{2{right_reg[sclp_pkg::CfgW-1]}}, right_reg, 4'b0};
        eb = {{2{bottom_reg[sclp_pkg::CfgW-1]}}, bottom_reg, 4'b0};
        px = {{2{pos_x[sclp_pkg::CoordW-1]}}, pos_x};
        py = {{2{pos_y[sclp_pkg::CoordW-1]}}, pos_y};
        rt = px + $signed({2'b0, width});
        bt = py + $signed({2'b0, height});
        cull = (px >= er) || (rt <= el) || (py >= eb) || (bt <= et);
        nl = clampv(px, el, er);
        nt = clampv(py, et, eb);
        nr = clampv(rt, el, er);
        nb = clampv(bt, et, eb);
        span_u = {tex_u2[sclp_pkg::CoordW-1], tex_u2} - {tex_u1[sclp_pkg::CoordW-1], tex_u1};
        span_v = {tex_v2[sclp_pkg::CoordW-1], tex_v2} - {tex_v1[sclp_pkg::CoordW-1], tex_v1};

        keep = !en_reg || !cull;

        job.pass.texture_id  = texture_id;
        job.pass.colour_rgba = colour_rgba;
        job.lane[0].coord = tex_u1;
        job.lane[1].coord = tex_u2;
        job.lane[2].coord = tex_v1;
        job.lane[3].coord = tex_v2;
        job.lane[0].span  = span_u;
        job.lane[1].span  = span_u;
        job.lane[2].span  = span_v;
        job.lane[3].span  = span_v;
        job.lane[0].size  = width;
        job.lane[1].size  = width;
        job.lane[2].size  = height;
        job.lane[3].size  = height;
        if (en_reg)
        begin
            job.pass.pos_x  = nl[sclp_pkg::CoordW-1:0];
            job.pass.pos_y  = nt[sclp_pkg::CoordW-1:0];
            job.pass.width  = nr[sclp_pkg::CoordW-1:0] - nl[sclp_pkg::CoordW-1:0];
            job.pass.height = nb[sclp_pkg::CoordW-1:0] - nt[sclp_pkg::CoordW-1:0];
            job.lane[0].delta = {nl[sclp_pkg::EdgeW-1], nl} - {px[sclp_pkg::EdgeW-1], px};
            job.lane[1].delta = {nr[sclp_pkg::EdgeW-1], nr} - {rt[sclp_pkg::EdgeW-1], rt};
            job.lane[2].delta = {nt[sclp_pkg::EdgeW-1], nt} - {py[sclp_pkg::EdgeW-1], py};
            job.lane[3].delta = {nb[sclp_pkg::EdgeW-1], nb} - {bt[sclp_pkg::EdgeW-1], bt};
        end
        else
        begin
            job.pass.pos_x  = pos_x;
            job.pass.pos_y  = pos_y;
            job.pass.width  = width;
            job.pass.height = height;
            job.lane[0].delta = '0;
            job.lane[1].delta = '0;
            job.lane[2].delta = '0;
            job.lane[3].delta = '0;
        end
    end

endmodule

// ===== design/sclp_queue.sv =====
// sclp_queue: short queue of classified sprites between front and back
// depends on sclp_pkg
module sclp_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  sclp_pkg::job_t push_job,
    output logic           full,
    output logic           pop,
    output sclp_pkg::job_t pop_job
);

    sclp_pkg::job_t                 q_reg [sclp_pkg::QDepth];
    logic [sclp_pkg::PtrW-1:0]      wr_reg, rd_reg;
    logic [sclp_pkg::CntW-1:0]      cnt_reg, cnt_next;

    assign pop     = (cnt_reg != '0);
    assign full    = (cnt_reg == sclp_pkg::CntW'(sclp_pkg::QDepth));
    assign pop_job = q_reg[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (!push && pop)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_reg] <= push_job;
    end

endmodule

// ===== design/sclp_back.sv =====
// sclp_back: pipelined texture coordinate shift, multiply then radix-32 divide
// depends on sclp_pkg
module sclp_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  sclp_pkg::job_t                     in_job,
    output logic                               done,
    output logic signed [sclp_pkg::CoordW-1:0] out_pos_x,
    output logic signed [sclp_pkg::CoordW-1:0] out_pos_y,
    output logic [sclp_pkg::CoordW-1:0]        out_width,
    output logic [sclp_pkg::CoordW-1:0]        out_height,
    output logic signed [sclp_pkg::CoordW-1:0] out_u1,
    output logic signed [sclp_pkg::CoordW-1:0] out_v1,
    output logic signed [sclp_pkg::CoordW-1:0] out_u2,
    output logic signed [sclp_pkg::CoordW-1:0] out_v2,
    output logic [sclp_pkg::CoordW-1:0]        out_texture_id,
    output logic [31:0]                        out_colour_rgba
);

    typedef struct packed {
        logic signed [sclp_pkg::CoordW-1:0] coord;
        logic signed [sclp_pkg::ProdW-1:0]  prod;
        logic [sclp_pkg::CoordW-1:0]        size;
    } mul_t;

    typedef struct packed {
        logic signed [sclp_pkg::CoordW-1:0] coord;
        logic                               neg;
        logic                               zero;
        logic [sclp_pkg::CoordW-1:0]        dsor;
        logic [sclp_pkg::RemW-1:0]          rem;
        logic [sclp_pkg::DivW-1:0]          num;
    } div_t;

    localparam int Stages = sclp_pkg::BackLat;

    function automatic div_t div_stage(input div_t s);
        div_t                       r;
        logic [sclp_pkg::RemW:0]    t;
        logic [sclp_pkg::RemW:0]    diff;
        logic                       ge;
        begin
            r = s;
            for (int i = 0; i < sclp_pkg::StepBits; i++)
            begin
                t     = {r.rem, r.num[sclp_pkg::DivW-1]};
                diff  = t - {1'b0, r.dsor};
                ge    = (t >= {1'b0, r.dsor});
                r.num = {r.num[sclp_pkg::DivW-2:0], ge};
                r.rem = ge ? diff[sclp_pkg::RemW-1:0] : t[sclp_pkg::RemW-1:0];
            end
            return r;
        end
    endfunction

    function automatic logic signed [sclp_pkg::CoordW-1:0] finish(input div_t s);
        logic signed [sclp_pkg::DivW+1:0] q;
        logic signed [sclp_pkg::DivW+1:0] sum;
        begin
            q   = $signed({2'b0, s.num});
            sum = {{(sclp_pkg::DivW+2-sclp_pkg::CoordW){s.coord[sclp_pkg::CoordW-1]}}, s.coord}
                  + (s.neg ? -q : q);
            if (s.zero)
                return s.coord;
            else if (sum > 37'sd32767)
                return 16'sh7fff;
            else if (sum < -37'sd32768)
                return 16'sh8000;
            else
                return sum[sclp_pkg::CoordW-1:0];
        end
    endfunction

    logic [Stages-1:0]  vld_reg, vld_next;
    sclp_pkg::pass_t    ps_reg [Stages];
    mul_t               mul_reg [sclp_pkg::Lanes];
    div_t               dv_reg [sclp_pkg::DivStages+1][sclp_pkg::Lanes];
    logic signed [sclp_pkg::CoordW-1:0] res_reg [sclp_pkg::Lanes];
    div_t               dv_init [sclp_pkg::Lanes];

    assign vld_next = {vld_reg[Stages-2:0], in_valid};

    always_comb
    begin
        for (int l = 0; l < sclp_pkg::Lanes; l++)
        begin
            logic [sclp_pkg::ProdW-1:0] mag;
            mag = mul_reg[l].prod[sclp_pkg::ProdW-1] ? -mul_reg[l].prod : mul_reg[l].prod;
            dv_init[l].coord = mul_reg[l].coord;
            dv_init[l].neg   = mul_reg[l].prod[sclp_pkg::ProdW-1];
            dv_init[l].zero  = (mul_reg[l].size == '0);
            dv_init[l].dsor  = mul_reg[l].size;
            dv_init[l].rem   = '0;
            dv_init[l].num   = mag[sclp_pkg::DivW-1:0]
                               + {{(sclp_pkg::DivW-sclp_pkg::CoordW+1){1'b0}},
                                  mul_reg[l].size[sclp_pkg::CoordW-1:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        ps_reg[0] <= in_job.pass;
        for (int k = 1; k < Stages; k++)
            ps_reg[k] <= ps_reg[k-1];
        for (int l = 0; l < sclp_pkg::Lanes; l++)
        begin
            mul_reg[l].coord <= in_job.lane[l].coord;
            mul_reg[l].size  <= in_job.lane[l].size;
            mul_reg[l].prod  <= in_job.lane[l].span * in_job.lane[l].delta;
            dv_reg[0][l]     <= dv_init[l];
            for (int k = 1; k <= sclp_pkg::DivStages; k++)
                dv_reg[k][l] <= div_stage(dv_reg[k-1][l]);
            res_reg[l]       <= finish(dv_reg[sclp_pkg::DivStages][l]);
        end
    end

    assign done            = vld_reg[Stages-1];
    assign out_pos_x       = ps_reg[Stages-1].pos_x;
    assign out_pos_y       = ps_reg[Stages-1].pos_y;
    assign out_width       = ps_reg[Stages-1].width;
    assign out_height      = ps_reg[Stages-1].height;
    assign out_texture_id  = ps_reg[Stages-1].texture_id;
    assign out_colour_rgba = ps_reg[Stages-1].colour_rgba;
    assign out_u1          = res_reg[0];
    assign out_u2          = res_reg[1];
    assign out_v1          = res_reg[2];
    assign out_v2          = res_reg[3];

    a_lat_hit: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |-> ##(sclp_pkg::BackLat) done)
        else $error("back pipeline dropped a transfer");

    a_lat_none: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid |-> ##(sclp_pkg::BackLat) !done)
        else $error("back pipeline invented a transfer");

    a_no_shift: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_job.lane[0].delta == '0) |-> ##(sclp_pkg::BackLat)
        (out_u1 == $past(in_job.lane[0].coord, sclp_pkg::BackLat)))
        else $error("u1 moved without an edge shift");

endmodule

// ===== sim/testbench.sv =====
// testbench for sprite_clip_uv_adjust_core: directed table then random sprites
// checked against a behavioral clip and uv predictor; depends on sclp_pkg and the core
module testbench;

    typedef struct packed {
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic [15:0]        w;
        logic [15:0]        h;
        logic signed [15:0] u1;
        logic signed [15:0] v1;
        logic signed [15:0] u2;
        logic signed [15:0] v2;
        logic [15:0]        tid;
        logic [31:0]        rgba;
    } sprite_t;

    typedef struct {
        sprite_t s;
        bit      has_exp;
        bit      exp_kept;
        sprite_t exp;
    } row_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [sclp_pkg::CfgIdxW-1:0] cfg_index;
    logic [sclp_pkg::CfgW-1:0] cfg_wdata;
    logic start;
    logic busy;
    logic done;
    sprite_t drv;
    sprite_t got;

    bit clip_on;
    int edge_l, edge_t, edge_r, edge_b;
    sprite_t sprites_due[$];
    int failures;
    int accepted;
    int produced;
    int culled;

    sprite_clip_uv_adjust_core u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .start(start), .busy(busy),
        .pos_x(drv.px), .pos_y(drv.py), .width(drv.w), .height(drv.h),
        .tex_u1(drv.u1), .tex_v1(drv.v1), .tex_u2(drv.u2), .tex_v2(drv.v2),
        .texture_id(drv.tid), .colour_rgba(drv.rgba),
        .done(done),
        .out_pos_x(got.px), .out_pos_y(got.py), .out_width(got.w), .out_height(got.h),
        .out_u1(got.u1), .out_v1(got.v1), .out_u2(got.u2), .out_v2(got.v2),
        .out_texture_id(got.tid), .out_colour_rgba(got.rgba)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #200000000;
        $display("testbench: errors");
        $finish;
    end

    function automatic int shifted_coord(int coord, int span, int d, int size);
        longint num;
        longint mag;
        longint q;
        longint res;
        if (size <= 0)
            return coord;
        num = longint'(span) * longint'(d);
        mag = (num < 0) ? -num : num;
        q = (mag + size / 2) / size;
        res = coord + ((num < 0) ? -q : q);
        if (res > 32767) res = 32767;
        if (res < -32768) res = -32768;
        return int'(res);
    endfunction

    function automatic int clamp_edge(int x, int lo, int hi);
        if (x < lo) x = lo;
        if (x > hi) x = hi;
        return x;
    endfunction

    function automatic bit clip_sprite(sprite_t s, output sprite_t r);
        int px, py, w, h, rt, bt, nl, nt, nr, nb;
        r = s;
        if (!clip_on)
            return 1'b1;
        px = s.px; py = s.py; w = s.w; h = s.h;
        rt = px + w; bt = py + h;
        if (px >= edge_r || rt <= edge_l || py >= edge_b || bt <= edge_t)
            return 1'b0;
        nl = clamp_edge(px, edge_l, edge_r);
        nt = clamp_edge(py, edge_t, edge_b);
        nr = clamp_edge(rt, edge_l, edge_r);
        nb = clamp_edge(bt, edge_t, edge_b);
        r.px = nl[15:0];
        r.py = nt[15:0];
        r.w = 16'(nr - nl);
        r.h = 16'(nb - nt);
        r.u1 = 16'(shifted_coord(s.u1, s.u2 - s.u1, nl - px, w));
        r.u2 = 16'(shifted_coord(s.u2, s.u2 - s.u1, nr - rt, w));
        r.v1 = 16'(shifted_coord(s.v1, s.v2 - s.v1, nt - py, h));
        r.v2 = 16'(shifted_coord(s.v2, s.v2 - s.v1, nb - bt, h));
        return 1'b1;
    endfunction

    task automatic write_reg(logic [sclp_pkg::CfgIdxW-1:0] idx, logic [sclp_pkg::CfgW-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            sclp_pkg::CFG_ENABLE: clip_on = val[0];
            sclp_pkg::CFG_LEFT:   edge_l = 16 * int'($signed(val));
            sclp_pkg::CFG_TOP:    edge_t = 16 * int'($signed(val));
            sclp_pkg::CFG_RIGHT:  edge_r = 16 * int'($signed(val));
            sclp_pkg::CFG_BOTTOM: edge_b = 16 * int'($signed(val));
            default: ;
        endcase
    endtask

    task automatic drain;
        int n;
        n = 0;
        start <= 1'b0;
        while (sprites_due.size() != 0 && n < 100000)
        begin
            @(posedge clk);
            n++;
        end
        repeat (sclp_pkg::BackLat + 6) @(posedge clk);
    endtask

    task automatic set_clip(bit en, int l, int t, int r, int b);
        drain();
        write_reg(sclp_pkg::CFG_ENABLE, {11'd0, en});
        write_reg(sclp_pkg::CFG_LEFT, 12'(l));
        write_reg(sclp_pkg::CFG_TOP, 12'(t));
        write_reg(sclp_pkg::CFG_RIGHT, 12'(r));
        write_reg(sclp_pkg::CFG_BOTTOM, 12'(b));
        cfg_wr_en <= 1'b0;
    endtask

    // one transfer into the block, with a random gap before it
    task automatic send(sprite_t s, bit check_fixed, bit fixed_kept, sprite_t fixed_exp);
        sprite_t r;
        bit kept;
        int gap;
        gap = $urandom_range(0, 3);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        drv <= s;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        kept = clip_sprite(s, r);
        if (check_fixed && (kept != fixed_kept || (kept && r != fixed_exp)))
        begin
            $error("table row disagrees with predictor: kept %0b/%0b", fixed_kept, kept);
            failures++;
        end
        accepted++;
        if (kept)
            sprites_due = {sprites_due, r};
        else
            culled++;
    endtask

    always @(posedge clk)
    begin
        sprite_t e;
        if (rst_n && done)
        begin
            produced++;
            if (sprites_due.size() == 0)
            begin
                $error("unexpected transfer on the result ports");
                failures++;
            end
            else
            begin
                e = sprites_due.pop_front();
                if (got.px !== e.px) begin $error("out_pos_x exp %h got %h", e.px, got.px); failures++; end
                if (got.py !== e.py) begin $error("out_pos_y exp %h got %h", e.py, got.py); failures++; end
                if (got.w !== e.w) begin $error("out_width exp %h got %h", e.w, got.w); failures++; end
                if (got.h !== e.h) begin $error("out_height exp %h got %h", e.h, got.h); failures++; end
                if (got.u1 !== e.u1) begin $error("out_u1 exp %h got %h", e.u1, got.u1); failures++; end
                if (got.v1 !== e.v1) begin $error("out_v1 exp %h got %h", e.v1, got.v1); failures++; end
                if (got.u2 !== e.u2) begin $error("out_u2 exp %h got %h", e.u2, got.u2); failures++; end
                if (got.v2 !== e.v2) begin $error("out_v2 exp %h got %h", e.v2, got.v2); failures++; end
                if (got.tid !== e.tid)
                begin
                    $error("out_texture_id exp %h got %h", e.tid, got.tid);
                    failures++;
                end
                if (got.rgba !== e.rgba)
                begin
                    $error("out_colour_rgba exp %h got %h", e.rgba, got.rgba);
                    failures++;
                end
            end
        end
    end

    function automatic sprite_t rand_sprite(bool_near_clip);
        sprite_t s;
        s = {$urandom, $urandom, $urandom, $urandom, $urandom, 16'($urandom)};
        if (bool_near_clip)
        begin
            s.px = 16'($signed($urandom_range(0, 1200)) - 600);
            s.py = 16'($signed($urandom_range(0, 1200)) - 600);
            s.w = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 900));
            s.h = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 900));
        end
        return s;
    endfunction

    row_t table_rows[$];

    task automatic add_row(sprite_t s, bit has_exp, bit exp_kept, sprite_t exp);
        row_t row;
        row.s = s;
        row.has_exp = has_exp;
        row.exp_kept = exp_kept;
        row.exp = exp;
        table_rows = {table_rows, row};
    endtask

    task automatic run_rows;
        foreach (table_rows[i])
            send(table_rows[i].s, table_rows[i].has_exp, table_rows[i].exp_kept,
                 table_rows[i].exp);
        table_rows.delete();
    endtask

    initial
    begin
        sprite_t s;
        sprite_t none;
        int k;
        int phase;
        failures = 0; accepted = 0; produced = 0; culled = 0;
        clip_on = 0; edge_l = 0; edge_t = 0; edge_r = 0; edge_b = 0;
        none = '0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0; cfg_index = '0; cfg_wdata = '0;
        start = 1'b0;
        drv = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // after reset: pass through, extremes of every field
        s = {16'sh8000, 16'sh7fff, 16'hffff, 16'h0000, 16'sh8000, 16'sh7fff,
             16'sh7fff, 16'sh8000, 16'hffff, 32'hffffffff};
        add_row(s, 1, 1, s);
        s = {16'sh7fff, 16'sh8000, 16'h0000, 16'hffff, 16'sh7fff, 16'sh8000,
             16'sh8000, 16'sh7fff, 16'h0000, 32'h00000000};
        add_row(s, 1, 1, s);
        s = '0;
        add_row(s, 1, 1, s);
        run_rows();

        set_clip(1, 0, 0, 100, 100);
        // fully outside on each side: culled
        s = {16'sd1600, 16'sd0, 16'd160, 16'd160, 64'd0, 16'd1, 32'd2};
        add_row(s, 1, 0, none);
        s = {-16'sd160, 16'sd0, 16'd160, 16'd160, 64'd0, 16'd1, 32'd2};
        add_row(s, 1, 0, none);
        s = {16'sd0, 16'sd1600, 16'd160, 16'd160, 64'd0, 16'd1, 32'd2};
        add_row(s, 1, 0, none);
        s = {16'sd0, -16'sd160, 16'd160, 16'd160, 64'd0, 16'd1, 32'd2};
        add_row(s, 1, 0, none);
        // half over the left edge: u1 moves halfway
        s = {-16'sd160, 16'sd0, 16'd320, 16'd160, 16'sd0, 16'sd0, 16'sd16384, 16'sd16384,
             16'h1234, 32'hdeadbeef};
        add_row(s, 1, 1, {16'sd0, 16'sd0, 16'd160, 16'd160, 16'sd8192, 16'sd0,
                          16'sd16384, 16'sd16384, 16'h1234, 32'hdeadbeef});
        // zero size, coordinates unchanged
        s = {16'sd16, 16'sd16, 16'd0, 16'd0, 16'sd5, 16'sd6, 16'sd7, 16'sd8, 16'd9, 32'd10};
        add_row(s, 1, 1, s);
        for (k = 0; k < 6; k++)
            add_row(rand_sprite(1), 0, 0, none);
        run_rows();

        // inverted rectangle, saturating shifts
        set_clip(1, 50, 50, 10, 10);
        for (k = 0; k < 5; k++)
        begin
            s = rand_sprite(1);
            s.u1 = 16'sh8000; s.u2 = 16'sh7fff;
            add_row(s, 0, 0, none);
        end
        run_rows();

        for (phase = 0; phase < 7; phase++)
        begin
            case (phase)
                0: set_clip(1, -2048, -2048, 2047, 2047);
                1: set_clip(1, -20, -20, 20, 20);
                2: set_clip(0, 7, 7, 7, 7);
                3: set_clip(1, 2047, 2047, -2048, -2048);
                4: set_clip(1, -2048, 2047, 2047, -2048);
                default: set_clip(1, $urandom_range(0, 80) - 40, $urandom_range(0, 80) - 40,
                                  $urandom_range(0, 80) - 10, $urandom_range(0, 80) - 10);
            endcase
            for (k = 0; k < 250; k++)
            begin
                send(rand_sprite($urandom_range(0, 4) != 0), 0, 0, none);
                if (k == 120)
                    drain();
            end
        end

        drain();
        $display("sent %0d sprites over several clip settings: %0d results, %0d culled",
                 accepted, produced, culled);
        if (failures == 0 && sprites_due.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end
endmodule

// ===== sprite_clip_uv_adjust_core.f =====
design/sclp_pkg.sv
design/sclp_front.sv
design/sclp_queue.sv
design/sclp_back.sv
design/sprite_clip_uv_adjust_core.sv
sim/testbench.sv
